// ===== src/mpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mpt_pkg
// Shared types and constants for the max priority table with promote.
// ----------------------------------------------------------------------------
package mpt_pkg;

	// fixed port field widths
	localparam int ACT_W     = 3;
	localparam int ID_W      = 32;
	localparam int PAY_IO_W  = 32;
	localparam int PRI_IO_W  = 16;
	localparam int STATUS_W  = 2;

	// default sizing of the table
	localparam int ENTRIES_DEF       = 16;
	localparam int PAYLOAD_BITS_DEF  = 32;
	localparam int PRIORITY_BITS_DEF = 16;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD      = 3'd0,
		ACT_IS_VALID = 3'd1,
		ACT_GET      = 3'd2,
		ACT_PROMOTE  = 3'd3,
		ACT_GET_MAX  = 3'd4,
		ACT_POP_MAX  = 3'd5
	} act_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_EMPTY     = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture request, restart scan
		logic rd;      // read slot at scan counter
		logic finish;  // commit update, load response register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;    // scan counter at final slot
	} stat_t;

endpackage

// ===== src/mpt_ifs.sv =====
// ----------------------------------------------------------------------------
// mpt request / response channels
// Valid/ready channels carrying the request and response fields.
// ----------------------------------------------------------------------------
interface mpt_req_if;
	logic                         valid;
	logic                         ready;
	logic [mpt_pkg::ACT_W-1:0]    action;
	logic [mpt_pkg::ID_W-1:0]     entry_id;
	logic [mpt_pkg::PAY_IO_W-1:0] payload_in;

	modport source (output valid, action, entry_id, payload_in, input ready);
	modport sink (input valid, action, entry_id, payload_in, output ready);
endinterface

interface mpt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mpt_pkg::STATUS_W-1:0] status;
	logic [mpt_pkg::ID_W-1:0]     id_out;
	logic [mpt_pkg::PAY_IO_W-1:0] payload_out;
	logic [mpt_pkg::PRI_IO_W-1:0] priority_out;
	logic                         is_present;

	modport source (output valid, status, id_out, payload_out, priority_out, is_present,
		input ready);
	modport sink (input valid, status, id_out, payload_out, priority_out, is_present,
		output ready);
endinterface

// ===== src/mpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpt_ctrl
// Sequencer: accept request, scan all slots, drain read stage, commit.
// ----------------------------------------------------------------------------
module mpt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output mpt_pkg::cmd_t   cmd,
	input  mpt_pkg::stat_t  sts
);

	mpt_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			mpt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = mpt_pkg::ST_SCAN;
				end
			end
			mpt_pkg::ST_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.last) begin
					state_d = mpt_pkg::ST_DRAIN;
				end
			end
			mpt_pkg::ST_DRAIN: begin
				// last slot's read data is folded in this cycle
				state_d = mpt_pkg::ST_DONE;
			end
			mpt_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = mpt_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// response register never overwritten while still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("response overwritten before taken");

	// no new request while a scan is running
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !in_ready)
		else $error("request accepted during scan");

	// scan ends by draining the read stage
	a_scan_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpt_pkg::ST_SCAN && sts.last) |=> state_q == mpt_pkg::ST_DRAIN)
		else $error("scan did not drain");

endmodule

// ===== src/mpt_dp.sv =====
// ----------------------------------------------------------------------------
// mpt_dp
// Slot memory, valid bits, id counter, scan trackers and response register.
// ----------------------------------------------------------------------------
module mpt_dp #(
	parameter int ENTRIES       = mpt_pkg::ENTRIES_DEF,
	parameter int PAYLOAD_BITS  = mpt_pkg::PAYLOAD_BITS_DEF,
	parameter int PRIORITY_BITS = mpt_pkg::PRIORITY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mpt_pkg::cmd_t                  cmd,
	output mpt_pkg::stat_t                 sts,
	input  logic [mpt_pkg::ACT_W-1:0]      action,
	input  logic [mpt_pkg::ID_W-1:0]       entry_id,
	input  logic [mpt_pkg::PAY_IO_W-1:0]   payload_in,
	output logic [mpt_pkg::STATUS_W-1:0]   status,
	output logic [mpt_pkg::ID_W-1:0]       id_out,
	output logic [mpt_pkg::PAY_IO_W-1:0]   payload_out,
	output logic [mpt_pkg::PRI_IO_W-1:0]   priority_out,
	output logic                           is_present
);

	localparam int IW = $clog2(ENTRIES);
	localparam int W  = mpt_pkg::ID_W;

	// slot memory: one read, one write per cycle
	logic [W-1:0]             id_mem  [ENTRIES];
	logic [PRIORITY_BITS-1:0] pri_mem [ENTRIES];
	logic [PAYLOAD_BITS-1:0]  pay_mem [ENTRIES];
	logic [ENTRIES-1:0]       used_q;

	// request
	logic [mpt_pkg::ACT_W-1:0] act_q;
	logic [W-1:0]              req_id_q;
	logic [PAYLOAD_BITS-1:0]   req_pay_q;

	logic [W-1:0]              next_id_q;
	logic [IW-1:0]             cnt_q;

	// read stage
	logic                      rd_vld_s1;
	logic [IW-1:0]             rd_idx_s1;
	logic                      used_s1;
	logic [W-1:0]              id_s1;
	logic [PRIORITY_BITS-1:0]  pri_s1;
	logic [PAYLOAD_BITS-1:0]   pay_s1;

	// scan trackers
	logic                      free_found_q;
	logic [IW-1:0]             free_idx_q;
	logic                      match_found_q;
	logic [IW-1:0]             match_idx_q;
	logic [PRIORITY_BITS-1:0]  match_pri_q;
	logic [PAYLOAD_BITS-1:0]   match_pay_q;
	logic                      best_found_q;
	logic [IW-1:0]             best_idx_q;
	logic [PRIORITY_BITS-1:0]  best_pri_q;
	logic [W-1:0]              best_age_q;
	logic [PAYLOAD_BITS-1:0]   best_pay_q;

	logic [W-1:0]              age_s1;
	logic                      take_best;

	// commit controls
	logic                      we_all;
	logic                      we_pri;
	logic [IW-1:0]             waddr;
	logic [PRIORITY_BITS-1:0]  wpri;
	logic                      set_used;
	logic                      clr_used;
	logic [mpt_pkg::STATUS_W-1:0] res_status;
	logic [W-1:0]                 res_id;
	logic [mpt_pkg::PAY_IO_W-1:0] res_pay;
	logic [mpt_pkg::PRI_IO_W-1:0] res_pri;
	logic                         res_present;

	assign sts.last = (cnt_q == IW'(ENTRIES - 1));

	// request capture and scan counter
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q     <= action;
			req_id_q  <= entry_id;
			req_pay_q <= PAYLOAD_BITS'(payload_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// memory
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			id_s1     <= id_mem[cnt_q];
			pri_s1    <= pri_mem[cnt_q];
			pay_s1    <= pay_mem[cnt_q];
			used_s1   <= used_q[cnt_q];
			rd_idx_s1 <= cnt_q;
		end
		if (we_all) begin
			id_mem[waddr]  <= next_id_q;
			pay_mem[waddr] <= req_pay_q;
		end
		if (we_all || we_pri) begin
			pri_mem[waddr] <= wpri;
		end
	end

	// smaller age means more recently added
	assign age_s1    = next_id_q - id_s1;
	assign take_best = used_s1 && (!best_found_q || pri_s1 > best_pri_q ||
		(pri_s1 == best_pri_q && age_s1 < best_age_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			best_found_q  <= 1'b0;
		end else if (cmd.load) begin
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			best_found_q  <= 1'b0;
		end else if (rd_vld_s1) begin
			if (!used_s1 && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (used_s1 && id_s1 == req_id_q && !match_found_q) begin
				match_found_q <= 1'b1;
			end
			if (take_best) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (!used_s1 && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
			if (used_s1 && id_s1 == req_id_q && !match_found_q) begin
				match_idx_q <= rd_idx_s1;
				match_pri_q <= pri_s1;
				match_pay_q <= pay_s1;
			end
			if (take_best) begin
				best_idx_q <= rd_idx_s1;
				best_pri_q <= pri_s1;
				best_age_q <= age_s1;
				best_pay_q <= pay_s1;
			end
		end
	end

	// commit decode
	always_comb begin
		we_all      = 1'b0;
		we_pri      = 1'b0;
		waddr       = match_idx_q;
		wpri        = match_pri_q + 1'b1;
		set_used    = 1'b0;
		clr_used    = 1'b0;
		res_status  = mpt_pkg::STS_OK;
		res_id      = '0;
		res_pay     = '0;
		res_pri     = '0;
		res_present = 1'b0;
		unique case (act_q)
			mpt_pkg::ACT_ADD: begin
				waddr = free_idx_q;
				wpri  = '0;
				if (free_found_q) begin
					we_all   = cmd.finish;
					set_used = cmd.finish;
					res_id   = next_id_q;
				end else begin
					res_status = mpt_pkg::STS_FULL;
				end
			end
			mpt_pkg::ACT_IS_VALID: begin
				res_present = match_found_q;
			end
			mpt_pkg::ACT_GET: begin
				if (match_found_q) begin
					res_pay = mpt_pkg::PAY_IO_W'(match_pay_q);
				end else begin
					res_status = mpt_pkg::STS_NOT_FOUND;
				end
			end
			mpt_pkg::ACT_PROMOTE: begin
				if (match_found_q) begin
					// saturate at all ones
					we_pri = cmd.finish && (match_pri_q != '1);
				end else begin
					res_status = mpt_pkg::STS_NOT_FOUND;
				end
			end
			mpt_pkg::ACT_GET_MAX, mpt_pkg::ACT_POP_MAX: begin
				if (best_found_q) begin
					res_pay  = mpt_pkg::PAY_IO_W'(best_pay_q);
					res_pri  = mpt_pkg::PRI_IO_W'(best_pri_q);
					clr_used = cmd.finish && (act_q == mpt_pkg::ACT_POP_MAX);
				end else begin
					res_status = mpt_pkg::STS_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			next_id_q <= '0;
		end else begin
			if (set_used) begin
				used_q[free_idx_q] <= 1'b1;
				next_id_q          <= next_id_q + 1'b1;
			end
			if (clr_used) begin
				used_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status       <= res_status;
			id_out       <= res_id;
			payload_out  <= res_pay;
			priority_out <= res_pri;
			is_present   <= res_present;
		end
	end

	a_add_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && act_q == mpt_pkg::ACT_ADD && free_found_q)
		|=> used_q[$past(free_idx_q)])
		else $error("add did not mark slot used");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && act_q == mpt_pkg::ACT_POP_MAX && best_found_q)
		|=> !used_q[$past(best_idx_q)])
		else $error("pop did not free slot");

endmodule

// ===== src/max_priority_table_with_promote.sv =====
// ----------------------------------------------------------------------------
// max_priority_table_with_promote
// Indexed max priority table with add, lookup, promote, get-max and pop-max.
//
//   channel  dir  fields
//   req      in   action, entry_id, payload_in
//   rsp      out  status, id_out, payload_out, priority_out, is_present
//
// Each request runs a full scan before the next is accepted: one slot of
// the single-read-port slot memory is read per cycle, then a drain state
// folds in the last read and a done state commits the update.
// Reset clears the valid bits and the id counter at once; no clearing pass.
// A new request is taken while the previous response is still held; the
// commit waits only if that response has not been taken by then.
// ----------------------------------------------------------------------------
module max_priority_table_with_promote #(
	parameter int ENTRIES       = mpt_pkg::ENTRIES_DEF,
	parameter int PAYLOAD_BITS  = mpt_pkg::PAYLOAD_BITS_DEF,
	parameter int PRIORITY_BITS = mpt_pkg::PRIORITY_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mpt_req_if.sink    req,
	mpt_rsp_if.source  rsp
);

	mpt_pkg::cmd_t  cmd;
	mpt_pkg::stat_t sts;

	mpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mpt_dp #(
		.ENTRIES       (ENTRIES),
		.PAYLOAD_BITS  (PAYLOAD_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (req.action),
		.entry_id     (req.entry_id),
		.payload_in   (req.payload_in),
		.status       (rsp.status),
		.id_out       (rsp.id_out),
		.payload_out  (rsp.payload_out),
		.priority_out (rsp.priority_out),
		.is_present   (rsp.is_present)
	);

endmodule
